/* rtl/core/vhd_pkg.sv */
// Shared types, constants and state codes of the voxel hash dedup filter.
`timescale 1ns / 1ps

package vhd_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_PROBE_DEF   = 16;

    localparam logic [31:0] INV_RES_RESET = 32'd1310720;
    localparam logic [31:0] HASH_MULT     = 32'd2654435761;

    localparam int KEY_W       = 64;
    localparam int EPOCH_W     = 8;
    localparam int CELL_LAT    = 3;
    localparam int CELL_WAIT_W = 2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               new_cloud;
    } t_point;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] cell_x;
        logic signed [31:0] cell_y;
        logic               set_overflow;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_CELL,
        S_HASH_GO,
        S_HASH_WAIT,
        S_READ,
        S_CHECK
    } t_state;

endpackage

/* rtl/core/vhd_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module vhd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/vhd_cell.sv */
// Three-stage quantizer from a Q16.16 coordinate to a saturated voxel index.
`timescale 1ns / 1ps

module vhd_cell (
    input  logic               i_clk,
    input  logic signed [31:0] i_coord,
    input  logic [31:0]        i_inv_res,
    output logic signed [31:0] o_cell
);

    logic        r_neg1;
    logic [31:0] r_mag;
    logic        r_neg2;
    logic [63:0] r_prod;
    logic [31:0] r_cell;

    logic [63:0] sum;
    logic [31:0] cell_mag;
    logic [31:0] cell_sat;

    always_comb begin
        sum      = r_prod + 64'h0000_0000_8000_0000;
        cell_mag = sum[63:32];
        if (r_neg2) begin
            cell_sat = (cell_mag > 32'h8000_0000) ? 32'h8000_0000 : cell_mag;
            cell_sat = ~cell_sat + 32'd1;
        end else begin
            cell_sat = cell_mag[31] ? 32'h7FFF_FFFF : cell_mag;
        end
    end

    // The magnitude of the most negative code is 2^31, which still fits unsigned.
    always_ff @(posedge i_clk) begin
        r_neg1 <= i_coord[31];
        r_mag  <= i_coord[31] ? (~i_coord + 32'd1) : i_coord;
        r_neg2 <= r_neg1;
        r_prod <= 64'(r_mag) * 64'(i_inv_res);
        r_cell <= cell_sat;
    end

    assign o_cell = r_cell;

endmodule

/* rtl/core/vhd_bucket.sv */
// Hash of a cell pair reduced to a table bucket, by reciprocal multiplication when the depth is not 2^n.
`timescale 1ns / 1ps

module vhd_bucket #(
    parameter int TABLE_DEPTH = vhd_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_cell_x,
    input  logic [31:0]                    i_cell_y,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_bucket
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    // Rounded-up reciprocal of the depth; with it the quotient of any 32-bit hash is exact.
    localparam logic [32:0] RECIP =
        33'(((64'd1 << (32 + AW)) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

    logic          r_hash_ok;
    logic          r_quot_ok;
    logic          r_rem_ok;
    logic [31:0]   r_h;
    logic [31:0]   r_quot;
    logic [AW-1:0] r_rem;

    logic [31:0]   hash;
    logic [64:0]   quot_prod;
    logic [31:0]   rem_full;

    always_comb begin
        hash      = i_cell_x ^ (i_cell_y * vhd_pkg::HASH_MULT);
        quot_prod = 65'(r_h) * 65'(RECIP);
        rem_full  = r_h - r_quot * DEPTH_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_ok <= 1'b0;
            r_quot_ok <= 1'b0;
            r_rem_ok  <= 1'b0;
        end else begin
            r_hash_ok <= i_start;
            r_quot_ok <= r_hash_ok && !IS_POW2;
            r_rem_ok  <= r_quot_ok;
        end
    end

    // Hash, then quotient, then remainder, one register stage each.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h <= hash;
        end
        if (r_hash_ok) begin
            r_quot <= 32'(quot_prod >> (32 + AW));
        end
        if (r_quot_ok) begin
            r_rem <= rem_full[AW-1:0];
        end
    end

    assign o_done   = IS_POW2 ? r_hash_ok : r_rem_ok;
    assign o_bucket = IS_POW2 ? r_h[AW-1:0] : r_rem;

endmodule

/* rtl/core/voxel_hash_dedup_filter.sv */
// Points are taken one at a time: busy stays high while a point passes the cell stages, the bucket
// hash and the slot probes (power-of-two depth), and a new word is taken only when the filter is idle again.
// A depth that is not a power of two adds the quotient and remainder stages of the bucket.
// Reset: a clearing pass writes every slot to mark it empty (busy high meanwhile);
// the same pass runs on every 255th new cloud when the slot epoch wraps.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module voxel_hash_dedup_filter #(
    parameter int TABLE_DEPTH = vhd_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_PROBE   = vhd_pkg::MAX_PROBE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  vhd_pkg::t_point  i_point,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    output logic             o_res_valid,
    output vhd_pkg::t_result o_result
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int PW  = $clog2(MAX_PROBE + 1);
    localparam int MW  = vhd_pkg::EPOCH_W + vhd_pkg::KEY_W;
    localparam logic [vhd_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [vhd_pkg::EPOCH_W-1:0] EPOCH_FIRST = vhd_pkg::EPOCH_W'(1);

    vhd_pkg::t_state  r_state, n_state;
    vhd_pkg::t_point  r_point;
    vhd_pkg::t_result r_result;
    logic             r_res_valid;
    logic             r_item;
    logic [31:0]      r_inv_res;
    logic [vhd_pkg::EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]    r_slot;
    logic [PW-1:0]    r_probe;
    logic [vhd_pkg::CELL_WAIT_W-1:0] r_wait;

    logic signed [31:0] cell_x, cell_y;
    logic               bucket_done;
    logic [AW-1:0]      bucket;
    logic [MW-1:0]      rdata;
    logic [vhd_pkg::KEY_W-1:0]   key;
    logic [vhd_pkg::EPOCH_W-1:0] tag;

    logic          accept;
    logic          slot_last;
    logic          probe_last;
    logic          hit;
    logic          empty;
    logic          ram_we;
    logic [MW-1:0] ram_wdata;
    logic          hash_start;
    logic          emit;
    logic          overflow;

    assign accept     = start && (r_state == vhd_pkg::S_IDLE);
    assign key        = {cell_x, cell_y};
    assign tag        = rdata[vhd_pkg::KEY_W +: vhd_pkg::EPOCH_W];
    assign slot_last  = (r_slot == AW'(TABLE_DEPTH - 1));
    assign probe_last = (r_probe == PW'(MAX_PROBE - 1));
    // A slot counts as occupied only when it was written in the current epoch.
    assign empty      = (tag != r_epoch);
    assign hit        = !empty && (rdata[vhd_pkg::KEY_W-1:0] == key);

    vhd_cell u_cell_x (
        .i_clk     (i_clk),
        .i_coord   (r_point.point_x),
        .i_inv_res (r_inv_res),
        .o_cell    (cell_x)
    );

    vhd_cell u_cell_y (
        .i_clk     (i_clk),
        .i_coord   (r_point.point_y),
        .i_inv_res (r_inv_res),
        .o_cell    (cell_y)
    );

    vhd_bucket #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_bucket (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_cell_x (cell_x),
        .i_cell_y (cell_y),
        .o_done   (bucket_done),
        .o_bucket (bucket)
    );

    vhd_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vhd_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_point.new_cloud && r_epoch == EPOCH_MAX) ?
                              vhd_pkg::S_CLEAR : vhd_pkg::S_CELL;
                end
            end
            vhd_pkg::S_CLEAR: begin
                if (slot_last) begin
                    n_state = r_item ? vhd_pkg::S_CELL : vhd_pkg::S_IDLE;
                end
            end
            vhd_pkg::S_CELL: begin
                if (r_wait == vhd_pkg::CELL_WAIT_W'(vhd_pkg::CELL_LAT - 1)) begin
                    n_state = vhd_pkg::S_HASH_GO;
                end
            end
            vhd_pkg::S_HASH_GO: n_state = vhd_pkg::S_HASH_WAIT;
            vhd_pkg::S_HASH_WAIT: begin
                if (bucket_done) begin
                    n_state = vhd_pkg::S_READ;
                end
            end
            vhd_pkg::S_READ: n_state = vhd_pkg::S_CHECK;
            vhd_pkg::S_CHECK: begin
                if (hit || empty || probe_last) begin
                    n_state = vhd_pkg::S_IDLE;
                end else begin
                    n_state = vhd_pkg::S_READ;
                end
            end
            default: n_state = vhd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ram_we     = 1'b0;
        ram_wdata  = {r_epoch, key};
        hash_start = 1'b0;
        emit       = 1'b0;
        overflow   = 1'b0;
        unique case (r_state)
            vhd_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            vhd_pkg::S_HASH_GO: hash_start = 1'b1;
            vhd_pkg::S_CHECK: begin
                if (!hit) begin
                    if (empty) begin
                        ram_we = 1'b1;
                        emit   = 1'b1;
                    end else if (probe_last) begin
                        emit     = 1'b1;
                        overflow = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vhd_pkg::S_CLEAR;
            r_res_valid <= 1'b0;
            r_item      <= 1'b0;
            r_inv_res   <= vhd_pkg::INV_RES_RESET;
            r_epoch     <= EPOCH_FIRST;
            r_slot      <= '0;
            r_probe     <= '0;
            r_wait      <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= emit;
            if (i_cfg_we) begin
                r_inv_res <= i_cfg_data;
            end
            unique case (r_state)
                vhd_pkg::S_IDLE: begin
                    r_wait <= '0;
                    if (accept) begin
                        r_point <= i_point;
                        r_item  <= 1'b1;
                        r_slot  <= '0;
                        if (i_point.new_cloud && r_epoch != EPOCH_MAX) begin
                            r_epoch <= r_epoch + EPOCH_FIRST;
                        end
                    end
                end
                vhd_pkg::S_CLEAR: begin
                    r_slot <= slot_last ? '0 : r_slot + AW'(1);
                    if (slot_last) begin
                        r_epoch <= EPOCH_FIRST;
                    end
                end
                vhd_pkg::S_CELL: r_wait <= r_wait + vhd_pkg::CELL_WAIT_W'(1);
                vhd_pkg::S_HASH_WAIT: begin
                    r_slot  <= bucket;
                    r_probe <= '0;
                end
                vhd_pkg::S_CHECK: begin
                    r_probe <= r_probe + PW'(1);
                    if (!hit && !empty && !probe_last) begin
                        r_slot <= slot_last ? '0 : r_slot + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result.out_x        <= r_point.point_x;
            r_result.out_y        <= r_point.point_y;
            r_result.cell_x       <= cell_x;
            r_result.cell_y       <= cell_y;
            r_result.set_overflow <= overflow;
        end
    end

    assign busy        = (r_state != vhd_pkg::S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule
